// File: rtl/tte_pkg.sv
// Shared types, codes and widths for the timer table engine.
// No dependencies; used by every module of the block.

package tte_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int MAX_FIRES_DEF  = 64;

  localparam int TIME_W = 63;
  localparam int SLOT_W = 5;
  localparam int OP_W   = 2;
  localparam int KIND_W = 3;

  // input word layout, lowest bit first
  localparam int EXP_LSB    = 0;
  localparam int PER_LSB    = EXP_LSB + TIME_W;
  localparam int SLOT_LSB   = PER_LSB + TIME_W;
  localparam int NOW_LSB    = SLOT_LSB + SLOT_W;
  localparam int IN_USED_W  = NOW_LSB + TIME_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // output word layout: slot, then expiry
  localparam int OUT_USED_W  = SLOT_W + TIME_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE_ONESHOT  = 2'd0,
    OP_CREATE_PERIODIC = 2'd1,
    OP_CANCEL          = 2'd2,
    OP_TICK            = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED     = 3'd0,
    KIND_FULL        = 3'd1,
    KIND_CANCELLED   = 3'd2,
    KIND_CANCEL_FREE = 3'd3,
    KIND_FIRED       = 3'd4
  } kind_t;

  typedef struct packed {
    logic load_in;
    logic cnt_inc;
    logic create_write;
    logic set_full;
    logic cancel_do;
    logic scan_start;
    logic scan_step;
    logic take_best;
    logic rearm;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic free_hit;
    logic cnt_last;
    logic scan_done;
    logic best_found;
    logic pend_valid;
    logic out_free;
    logic cap_hit;
  } sts_t;

endpackage

// File: rtl/tte_ctrl.sv
// Sequencer for the timer table engine: one-hot state machine.
// Depends on tte_pkg; drives tte_dpath through cmd_t, reads sts_t.

module tte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tte_pkg::op_t  in_op,
  output logic          in_ready,
  input  tte_pkg::sts_t sts,
  output tte_pkg::cmd_t cmd
);
  import tte_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CREATE   = 8'b0000_0010,
    ST_CANCEL   = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_DECIDE   = 8'b0001_0000,
    ST_FIRE_RD  = 8'b0010_0000,
    ST_FIRE_UPD = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no word is taken while reset is held
  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          unique case (in_op)
            OP_CREATE_ONESHOT,
            OP_CREATE_PERIODIC: state_next = ST_CREATE;
            OP_CANCEL:          state_next = ST_CANCEL;
            OP_TICK: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            default:            state_next = ST_IDLE;
          endcase
        end
      end
      ST_CREATE: begin
        priority if (sts.free_hit) begin
          cmd.create_write = 1'b1;
          state_next       = ST_FINISH;
        end else if (sts.cnt_last) begin
          cmd.set_full = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_CANCEL: begin
        cmd.cancel_do = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        priority if (sts.best_found) begin
          // an older firing must leave first; it is not the last one
          if (!sts.pend_valid || sts.out_free) begin
            cmd.take_best = 1'b1;
            state_next    = ST_FIRE_RD;
          end
        end else if (sts.pend_valid) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIRE_RD: begin
        state_next = ST_FIRE_UPD;
      end
      ST_FIRE_UPD: begin
        cmd.rearm = 1'b1;
        if (sts.cap_hit) begin
          state_next = ST_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/tte_dpath.sv
// Datapath of the timer table engine: slot valid bits, expiry and period
// memories, scan counter, earliest-expiry compare, pending and output words.
// Depends on tte_pkg; controlled by tte_ctrl.

module tte_dpath #(
  parameter int NUM_TIMERS         = tte_pkg::NUM_TIMERS_DEF,
  parameter int MAX_FIRES_PER_TICK = tte_pkg::MAX_FIRES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tte_pkg::cmd_t                    cmd,
  output tte_pkg::sts_t                    sts,
  input  tte_pkg::op_t                     in_op,
  input  logic [tte_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tte_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output tte_pkg::kind_t                   out_kind,
  output logic                             out_last
);
  import tte_pkg::*;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);
  localparam int WIDE_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int PAD_W  = OUT_TDATA_W - OUT_USED_W;

  // latched input word
  logic [TIME_W-1:0] in_exp, in_per, in_now;
  logic [SLOT_W-1:0] in_slot;
  logic              in_periodic;

  logic [NUM_TIMERS-1:0] valid;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      cnt_idx;
  logic [FIRE_W-1:0]     fire_cnt;

  // memories: expiry, and {periodic, period}
  logic [TIME_W-1:0] exp_mem [NUM_TIMERS];
  logic [TIME_W:0]   per_mem [NUM_TIMERS];
  logic [TIME_W-1:0] exp_rd;
  logic [TIME_W:0]   per_rd;
  logic              exp_we;
  logic [IDX_W-1:0]  exp_wa;
  logic [TIME_W-1:0] exp_wd;

  // scan compare stage
  logic              rd_live;
  logic [IDX_W-1:0]  rd_idx;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_exp;
  logic              best_hit;

  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_exp;

  logic              cancel_hit;
  logic [IDX_W-1:0]  cancel_idx;

  logic              pend_valid;
  kind_t             pend_kind;
  logic [SLOT_W-1:0] pend_slot;
  logic [TIME_W-1:0] pend_exp;

  logic              load_out;
  logic [SLOT_W-1:0] out_slot;
  logic [TIME_W-1:0] out_exp;

  assign cnt_idx    = cnt[IDX_W-1:0];
  assign cancel_idx = IDX_W'(in_slot);
  assign cancel_hit = (WIDE_W'(in_slot) < WIDE_W'(NUM_TIMERS)) && valid[cancel_idx];

  assign best_hit = rd_live && (exp_rd <= in_now) && (!best_found || (exp_rd < best_exp));

  // re-arm saturates at the top of the time range
  assign rearm_sum = {1'b0, best_exp} + {1'b0, per_rd[TIME_W-1:0]};
  assign rearm_exp = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];

  assign load_out = (cmd.take_best && pend_valid) || cmd.emit_last;

  assign sts.free_hit   = !valid[cnt_idx];
  assign sts.cnt_last   = (cnt == CNT_W'(NUM_TIMERS - 1));
  assign sts.scan_done  = (cnt == CNT_W'(NUM_TIMERS));
  assign sts.best_found = best_found;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.cap_hit    = (fire_cnt == FIRE_W'(MAX_FIRES_PER_TICK));

  assign exp_we = cmd.create_write || (cmd.rearm && per_rd[TIME_W]);
  assign exp_wa = cmd.create_write ? cnt_idx : best_idx;
  assign exp_wd = cmd.create_write ? in_exp : rearm_exp;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      cnt        <= '0;
      fire_cnt   <= '0;
      rd_live    <= 1'b0;
      best_found <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_live <= cmd.scan_step && (cnt < CNT_W'(NUM_TIMERS)) && valid[cnt_idx];
      if (cmd.scan_start) begin
        best_found <= 1'b0;
      end else if (best_hit) begin
        best_found <= 1'b1;
      end
      if (cmd.load_in || cmd.scan_start) begin
        cnt <= '0;
      end else if (cmd.cnt_inc || cmd.scan_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.load_in) begin
        fire_cnt <= '0;
      end
      if (cmd.create_write) begin
        valid[cnt_idx] <= 1'b1;
        pend_valid     <= 1'b1;
      end
      if (cmd.set_full) begin
        pend_valid <= 1'b1;
      end
      if (cmd.cancel_do) begin
        if (cancel_hit) begin
          valid[cancel_idx] <= 1'b0;
        end
        pend_valid <= 1'b1;
      end
      if (cmd.take_best) begin
        pend_valid <= 1'b1;
        fire_cnt   <= fire_cnt + FIRE_W'(1);
      end
      if (cmd.rearm && !per_rd[TIME_W]) begin
        valid[best_idx] <= 1'b0;
      end
      if (cmd.emit_last) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // expiry memory: written on create and re-arm, read by the scan
  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    exp_rd <= exp_mem[cnt_idx];
  end

  // period memory: written on create, read at the chosen slot
  always_ff @(posedge clk) begin
    if (cmd.create_write) begin
      per_mem[cnt_idx] <= {in_periodic, in_periodic ? in_per : '0};
    end
    per_rd <= per_mem[best_idx];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_exp      <= in_tdata[EXP_LSB +: TIME_W];
      in_per      <= in_tdata[PER_LSB +: TIME_W];
      in_slot     <= in_tdata[SLOT_LSB +: SLOT_W];
      in_now      <= in_tdata[NOW_LSB +: TIME_W];
      in_periodic <= (in_op == OP_CREATE_PERIODIC);
    end
    rd_idx <= cnt_idx;
    if (best_hit) begin
      best_idx <= rd_idx;
      best_exp <= exp_rd;
    end
    priority if (cmd.take_best) begin
      pend_kind <= KIND_FIRED;
      pend_slot <= SLOT_W'(best_idx);
      pend_exp  <= best_exp;
    end else if (cmd.create_write) begin
      pend_kind <= KIND_CREATED;
      pend_slot <= SLOT_W'(cnt_idx);
      pend_exp  <= '0;
    end else if (cmd.set_full) begin
      pend_kind <= KIND_FULL;
      pend_slot <= '0;
      pend_exp  <= '0;
    end else if (cmd.cancel_do) begin
      pend_kind <= cancel_hit ? KIND_CANCELLED : KIND_CANCEL_FREE;
      pend_slot <= in_slot;
      pend_exp  <= '0;
    end
    if (load_out) begin
      out_kind <= pend_kind;
      out_slot <= pend_slot;
      out_exp  <= pend_exp;
      out_last <= cmd.emit_last;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, out_exp, out_slot};

endmodule

// File: rtl/timer_table_engine_core.sv
// Top level of the timer table engine: controller plus datapath.
// Depends on tte_pkg, tte_ctrl and tte_dpath.
//
//  channel  | dir | tdata fields (low bit up)                     | tuser     | tlast
//  ---------+-----+-----------------------------------------------+-----------+------
//  s_axis   | in  | expiry_time, period, slot_index, current_time | operation | -
//  m_axis   | out | timer_slot, fired_expiry                      | result_kind | last
//
// Flow: one word at a time. Create walks the valid bits from slot 0 up to
// the first free slot, or reports the table full. A tick scans the expiry
// memory one slot per cycle and fires the earliest due timer, then scans
// again for the next firing; the expiry memory has a single read port.
// Reset (rst, synchronous) clears all slots, no clearing pass is needed.
// Stalls: m_axis_tready low holds the output register; a new input word is
// still taken while the last result of the previous word waits there.

module timer_table_engine_core #(
  parameter int NUM_TIMERS         = tte_pkg::NUM_TIMERS_DEF,
  parameter int MAX_FIRES_PER_TICK = tte_pkg::MAX_FIRES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [62:0] expiry_time, [125:63] period, [130:126] slot_index,
  // [193:131] current_time, rest zero
  input  logic [tte_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [tte_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [4:0] timer_slot, [67:5] fired_expiry, rest zero
  output logic [tte_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [2:0] result_kind
  output logic [tte_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import tte_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  op_t   in_op;
  kind_t out_kind;

  assign in_op        = op_t'(s_axis_tuser);
  assign m_axis_tuser = out_kind;

  tte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (in_op),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tte_dpath #(
    .NUM_TIMERS         (NUM_TIMERS),
    .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_op),
    .in_tdata  (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tdata (m_axis_tdata),
    .out_kind  (out_kind),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: rtl/tte_checker.sv
// Port-level checks for the timer table engine, bound to the top level.
// Depends on tte_pkg and timer_table_engine_core.

module tte_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tte_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [tte_pkg::KIND_W-1:0]       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import tte_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result word changed under stall");

  // one word in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // create and cancel results are single, with no expiry
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != KIND_FIRED) |->
      m_axis_tlast && (m_axis_tdata[SLOT_W +: TIME_W] == '0))
    else $error("non-firing result malformed");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_FULL) |-> (m_axis_tdata[SLOT_W-1:0] == '0))
    else $error("table-full result carries a slot");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind timer_table_engine_core tte_checker u_tte_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/timer_table_engine_core_tb.sv
// Self-checking bench for timer_table_engine_core: a directed table, then random words.
// Depends on tte_pkg and the RTL of the block; results are checked against a local timer model.

module timer_table_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tte_pkg::*;

  localparam int SLOTS       = NUM_TIMERS_DEF;
  localparam int FIRE_CAP    = MAX_FIRES_DEF;
  localparam int RAND_WORDS  = 150;
  // longest quiet stretch: one firing scan plus a long stall on either side
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS  = 100;

  typedef logic [TIME_W-1:0] ns_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    op_t   op;
    ns_t   expiry;
    ns_t   period;
    slot_t slot;
    ns_t   now;
  } request_t;

  typedef struct packed {
    kind_t kind;
    slot_t slot;
    ns_t   expiry;
    logic  last;
  } result_t;

  // one row of the directed table; 'typed' rows carry their own expected word
  typedef struct packed {
    request_t req;
    int       reps;
    bit       typed;
    result_t  want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = OP_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  // timer model state
  bit  tmr_live   [SLOTS];
  bit  tmr_repeat [SLOTS];
  ns_t tmr_due    [SLOTS];
  ns_t tmr_period [SLOTS];

  result_t pending_results [$];
  row_t    dir_rows [$];

  int errors = 0;
  int quiet  = 0;
  int cycle  = 0;

  always #4 clk = ~clk;

  timer_table_engine_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic ns_t rand63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t mk_result(kind_t k, slot_t s, ns_t e, logic l);
    result_t r;
    r.kind   = k;
    r.slot   = s;
    r.expiry = e;
    r.last   = l;
    return r;
  endfunction

  function automatic row_t mk_row(op_t op, ns_t expiry, ns_t period, slot_t slot, ns_t now,
                                  int reps, bit typed, kind_t k, slot_t ws);
    row_t row;
    row.req.op     = op;
    row.req.expiry = expiry;
    row.req.period = period;
    row.req.slot   = slot;
    row.req.now    = now;
    row.reps       = reps;
    row.typed      = typed;
    row.want       = mk_result(k, ws, '0, 1'b1);
    return row;
  endfunction

  // expected words, oldest first
  function automatic void queue_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Timer model: updates the table and queues the words the request causes.
  task automatic predict_timers(input request_t req);
    int      idx;
    int      best;
    int      fires;
    bit      have;
    result_t held;
    logic [TIME_W:0] sum;
    unique case (req.op)
      OP_CREATE_ONESHOT, OP_CREATE_PERIODIC: begin
        idx = -1;
        for (int i = 0; i < SLOTS; i++)
          if (idx < 0 && !tmr_live[i]) idx = i;
        if (idx < 0) begin
          queue_result(mk_result(KIND_FULL, '0, '0, 1'b1));
        end else begin
          tmr_live[idx]   = 1'b1;
          tmr_repeat[idx] = (req.op == OP_CREATE_PERIODIC);
          tmr_due[idx]    = req.expiry;
          // one-shot keeps no period
          tmr_period[idx] = (req.op == OP_CREATE_PERIODIC) ? req.period : '0;
          queue_result(mk_result(KIND_CREATED, slot_t'(idx), '0, 1'b1));
        end
      end
      OP_CANCEL: begin
        if (tmr_live[req.slot]) begin
          tmr_live[req.slot] = 1'b0;
          queue_result(mk_result(KIND_CANCELLED, req.slot, '0, 1'b1));
        end else begin
          queue_result(mk_result(KIND_CANCEL_FREE, req.slot, '0, 1'b1));
        end
      end
      default: begin
        // tick: earliest due first, lower slot on ties, capped per tick
        fires = 0;
        best  = 0;
        have  = 1'b0;
        while (fires < FIRE_CAP && best >= 0) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tmr_live[i] && tmr_due[i] <= req.now &&
                (best < 0 || tmr_due[i] < tmr_due[best]))
              best = i;
          if (best >= 0) begin
            if (have) queue_result(held);
            held  = mk_result(KIND_FIRED, slot_t'(best), tmr_due[best], 1'b0);
            have  = 1'b1;
            fires++;
            if (tmr_repeat[best]) begin
              // re-arm saturates at the top of the time range
              sum = {1'b0, tmr_due[best]} + {1'b0, tmr_period[best]};
              tmr_due[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
              tmr_live[best] = 1'b0;
            end
          end
        end
        if (have) begin
          held.last = 1'b1;
          queue_result(held);
        end
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // tvalid is lowered only when a gap is wanted, so it never toggles twice in one step.
  task automatic send_word(input request_t req, input int gap, input bit typed,
                           input result_t want);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[EXP_LSB  +: TIME_W] = req.expiry;
    word[PER_LSB  +: TIME_W] = req.period;
    word[SLOT_LSB +: SLOT_W] = req.slot;
    word[NOW_LSB  +: TIME_W] = req.now;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tuser  <= req.op;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_timers(req);
    // typed rows are single-word creates or cancels: swap in the hand-written word
    if (typed) begin
      pending_results.delete(pending_results.size() - 1);
      queue_result(want);
    end
    @(negedge clk);
  endtask

  // Output side: ready in bursts, with quiet phases of no stall at all.
  initial begin : ready_driver
    int len;
    int gap;
    @(negedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      len = $urandom_range(1, 12);
      repeat (len) @(negedge clk);
      gap = (((cycle / 1500) % 3) == 2) ? 0 : gap_len();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Result check, oldest expectation first.
  always @(posedge clk) begin : check_out
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d slot %0d expiry %0d",
                                  m_axis_tuser, m_axis_tdata[4:0],
                                  m_axis_tdata[SLOT_W +: TIME_W]));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[0 +: SLOT_W] !== want.slot)
          report_mismatch($sformatf("timer_slot %0d, want %0d",
                                    m_axis_tdata[0 +: SLOT_W], want.slot));
        if (m_axis_tdata[SLOT_W +: TIME_W] !== want.expiry)
          report_mismatch($sformatf("fired_expiry %0d, want %0d",
                                    m_axis_tdata[SLOT_W +: TIME_W], want.expiry));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    request_t req;
    result_t  none;
    int       r;
    int       n;
    int       gap;
    int       live_list [SLOTS];
    ns_t      base;

    none = mk_result(KIND_CREATED, '0, '0, 1'b1);
    for (int i = 0; i < SLOTS; i++) begin
      tmr_live[i]   = 1'b0;
      tmr_repeat[i] = 1'b0;
      tmr_due[i]    = '0;
      tmr_period[i] = '0;
    end

    // Directed part. Fields: op, expiry, period, slot, now, repeats, typed, kind, slot.
    // cancels on an empty table, then a tick with nothing due
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd0, '0, 1, 1, KIND_CANCEL_FREE, 5'd0));
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd31, '0, 1, 1, KIND_CANCEL_FREE, 5'd31));
    add_row(mk_row(OP_TICK, '0, '0, '0, '0, 1, 0, KIND_FIRED, '0));
    // one-shot ignores its period field
    add_row(mk_row(OP_CREATE_ONESHOT, '0, TIME_MAX, '0, '0, 1, 1,
                   KIND_CREATED, 5'd0));
    add_row(mk_row(OP_CREATE_PERIODIC, 63'd10, 63'd5, '0, '0, 1, 1,
                   KIND_CREATED, 5'd1));
    add_row(mk_row(OP_CREATE_ONESHOT, TIME_MAX, '0, '0, '0, 1, 1,
                   KIND_CREATED, 5'd2));
    // re-arm of this one saturates
    add_row(mk_row(OP_CREATE_PERIODIC, TIME_MAX - 63'd3, TIME_MAX, '0, '0, 1, 1,
                   KIND_CREATED, 5'd3));
    // period zero: fires at every chance
    add_row(mk_row(OP_CREATE_PERIODIC, 63'd7, '0, '0, '0, 1, 1,
                   KIND_CREATED, 5'd4));
    add_row(mk_row(OP_TICK, '0, '0, '0, '0, 1, 0, KIND_FIRED, '0));
    // zero-period timer eats the whole fire cap, slot 1 stays pending
    add_row(mk_row(OP_TICK, '0, '0, '0, 63'd20, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd4, '0, 1, 1, KIND_CANCELLED, 5'd4));
    add_row(mk_row(OP_TICK, '0, '0, '0, 63'd20, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_TICK, '0, '0, '0, TIME_MAX, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd1, '0, 1, 1, KIND_CANCELLED, 5'd1));
    // saturated periodic ties with the one-shot at the top of the range
    add_row(mk_row(OP_TICK, '0, '0, '0, TIME_MAX, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd3, '0, 1, 1, KIND_CANCELLED, 5'd3));
    // fill every slot, one more create finds the table full
    add_row(mk_row(OP_CREATE_ONESHOT, 63'd100, '0, '0, '0, SLOTS, 0,
                   KIND_CREATED, '0));
    add_row(mk_row(OP_CREATE_PERIODIC, 63'd1, 63'd1, '0, '0, 1, 1, KIND_FULL, '0));
    add_row(mk_row(OP_TICK, '0, '0, '0, 63'd99, 1, 0, KIND_FIRED, '0));
    // all due at once: equal expiry, fired in slot order
    add_row(mk_row(OP_TICK, '0, '0, '0, 63'd100, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_CREATE_PERIODIC, 63'd50, TIME_MAX, '0, '0, 1, 1,
                   KIND_CREATED, 5'd0));
    add_row(mk_row(OP_TICK, '0, '0, '0, TIME_MAX, 1, 0, KIND_FIRED, '0));
    add_row(mk_row(OP_CANCEL, '0, '0, 5'd0, '0, 1, 1, KIND_CANCELLED, 5'd0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k])
      for (int j = 0; j < dir_rows[k].reps; j++)
        send_word(dir_rows[k].req, gap_len(), dir_rows[k].typed, dir_rows[k].want);

    // Random part: a running clock value keeps most timers near the ticks so
    // they fire; a few words are pure noise over the full field ranges.
    base = 63'd1000;
    for (int sent = 0; sent < RAND_WORDS; sent++) begin
      req.op     = OP_TICK;
      req.expiry = rand63();
      req.period = rand63();
      req.slot   = slot_t'($urandom);
      req.now    = rand63();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        req.op = op_t'($urandom_range(0, 3));
      end else if (r < 26) begin
        req.op     = OP_CREATE_ONESHOT;
        req.expiry = base + ns_t'($urandom_range(0, 400));
      end else if (r < 44) begin
        req.op     = OP_CREATE_PERIODIC;
        req.expiry = base + ns_t'($urandom_range(0, 400));
        req.period = ($urandom_range(0, 99) < 4) ? '0 : ns_t'($urandom_range(20, 200));
      end else if (r < 66) begin
        req.op = OP_CANCEL;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tmr_live[i]) begin
            live_list[n] = i;
            n++;
          end
        if (n > 0 && $urandom_range(0, 9) < 7)
          req.slot = slot_t'(live_list[$urandom_range(0, n - 1)]);
      end else begin
        req.op = OP_TICK;
        if ($urandom_range(0, 9) == 0) begin
          // time running backwards
          req.now = base - ns_t'($urandom_range(0, 300));
        end else begin
          base    = base + ns_t'($urandom_range(0, 150));
          req.now = base;
        end
      end
      // every fourth block of 40 words goes without input gaps
      gap = (((sent / 40) % 4) == 3) ? 0 : gap_len();
      send_word(req, gap, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // give a late extra word time to show up
    repeat (4 * SLOTS) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: timer_table_engine_core.f
rtl/tte_pkg.sv
rtl/tte_ctrl.sv
rtl/tte_dpath.sv
rtl/timer_table_engine_core.sv
rtl/tte_checker.sv
tb/timer_table_engine_core_tb.sv
